/* src/fbc_pkg.sv */
// Shared sizes and the store request bundle for the framebuffer command port.
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;

  localparam int PIX_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int COL_DEPTH = (SCREEN_WIDTH / 32) * (SCREEN_HEIGHT / 32) * 2;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);
  localparam int COL_AW    = $clog2(COL_DEPTH);
  localparam int SW_SHIFT  = $clog2(SCREEN_WIDTH);
  localparam int CLR_W     = PIX_AW + 1;

  typedef struct packed {
    logic              pix_rd;
    logic [PIX_AW-1:0] pix_addr;
    logic              pix_we;
    logic [7:0]        pix_wdata;
    logic              col_rd;
    logic [COL_AW-1:0] col_addr;
    logic              col_we;
    logic [7:0]        col_wdata;
  } mem_req_t;

endpackage

/* src/fbc_stores.sv */
// Pixel and color stores with the post-reset clearing sweep.
`timescale 1ns / 1ps

module fbc_stores (
  input  logic                         clk,
  input  logic                         rst,
  input  fbc_pkg::mem_req_t            req,
  output logic [7:0]                   pix_rdata,
  output logic [7:0]                   col_rdata,
  output logic                         busy
);

  logic [7:0] pix_mem [fbc_pkg::PIX_DEPTH];
  logic [7:0] col_mem [fbc_pkg::COL_DEPTH];

  logic [fbc_pkg::CLR_W-1:0] clr_cnt;
  logic                      col_clr;

  assign busy    = (clr_cnt != fbc_pkg::CLR_W'(fbc_pkg::PIX_DEPTH));
  assign col_clr = (clr_cnt < fbc_pkg::CLR_W'(fbc_pkg::COL_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      pix_mem[clr_cnt[fbc_pkg::PIX_AW-1:0]] <= 8'h00;
    end else if (req.pix_we) begin
      pix_mem[req.pix_addr] <= req.pix_wdata;
    end
    if (req.pix_rd) begin
      pix_rdata <= pix_mem[req.pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (col_clr) begin
        col_mem[clr_cnt[fbc_pkg::COL_AW-1:0]] <= 8'h00;
      end
    end else if (req.col_we) begin
      col_mem[req.col_addr] <= req.col_wdata;
    end
    if (req.col_rd) begin
      col_rdata <= col_mem[req.col_addr];
    end
  end

endmodule

/* src/fbc_engine.sv */
// Mode, pointer and region registers; decodes each beat and does the store update.
`timescale 1ns / 1ps

module fbc_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 exec,
  input  logic [1:0]           cmd,
  input  logic [7:0]           value,
  input  logic [7:0]           key_code,
  input  logic [7:0]           pix_rdata,
  input  logic [7:0]           col_rdata,
  output fbc_pkg::mem_req_t    req,
  output logic [7:0]           result
);

  typedef enum logic [4:0] {
    M_PIX_RW, M_COL_RW, M_PPTR_HI, M_PPTR_LO, M_CPTR_HI, M_CPTR_LO,
    M_KEY, M_RX_HI, M_RX_LO, M_RY_HI, M_RY_LO, M_RW_HI, M_RW_LO,
    M_RH_HI, M_RH_LO, M_OR, M_XOR, M_AND, M_ACK
  } mode_t;

  localparam logic [1:0] CMD_COMMAND = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] OP_PPTR     = 8'h00;
  localparam logic [7:0] OP_CPTR     = 8'h01;
  localparam logic [7:0] OP_PIX      = 8'h02;
  localparam logic [7:0] OP_COL      = 8'h03;
  localparam logic [7:0] OP_PDEC     = 8'h04;
  localparam logic [7:0] OP_CDEC     = 8'h05;
  localparam logic [7:0] OP_KEY      = 8'h10;
  localparam logic [7:0] OP_ORIGIN   = 8'h20;
  localparam logic [7:0] OP_SIZE     = 8'h21;
  localparam logic [7:0] OP_NOREGION = 8'h22;
  localparam logic [7:0] OP_OR       = 8'h23;
  localparam logic [7:0] OP_XOR      = 8'h24;
  localparam logic [7:0] OP_AND      = 8'h25;
  localparam logic [7:0] OP_ACK      = 8'hFF;

  localparam logic [7:0] ACK_BYTE    = 8'h42;

  localparam int ORG_W     = 16 + fbc_pkg::SW_SHIFT + 1;
  localparam int END_SUM_W = 16 + fbc_pkg::SW_SHIFT + 2;
  localparam int END_W     = END_SUM_W - 3;
  localparam int STRIDE_W  = 14;

  localparam logic [16:0] SW17     = 17'(fbc_pkg::SCREEN_WIDTH);
  localparam logic [31:0] PIX_LIM  = 32'(fbc_pkg::PIX_DEPTH);

  logic [1:0]  cmd_q;
  logic [7:0]  value_q;
  logic [7:0]  key_q;

  logic [15:0] pixel_pointer, pixel_pointer_next;
  logic [15:0] color_pointer, color_pointer_next;
  logic        region_enable, region_enable_next;
  logic [15:0] region_left, region_left_next;
  logic [15:0] region_top, region_top_next;
  logic [15:0] region_span, region_span_next;
  mode_t       current_mode, current_mode_next;
  mode_t       saved_mode, saved_mode_next;

  logic [STRIDE_W-1:0] region_stride;
  logic [12:0]         region_fold;
  logic [END_W-1:0]    region_end;

  logic [16:0]          stride_sum;
  logic [END_SUM_W-1:0] end_sum;
  logic [15:0]          org_top;
  logic [ORG_W-1:0]     org_sum;
  logic [15:0]          origin_ptr;
  logic [15:0]          reg_sum;
  logic [15:0]          reg_step;
  logic [15:0]          lin_sum;
  logic [15:0]          lin_step;
  logic [15:0]          pix_step;
  logic [15:0]          pix_step_acc;
  logic [15:0]          col_sum;
  logic [15:0]          col_step;

  assign stride_sum = {1'b0, region_span} + SW17;
  assign end_sum    = END_SUM_W'({region_top, fbc_pkg::SW_SHIFT'(0)})
                    + END_SUM_W'(region_left) + END_SUM_W'(region_span);

  assign org_top    = (current_mode == M_RY_LO) ? {region_top[15:8], value_q} : region_top;
  assign org_sum    = ORG_W'({org_top, fbc_pkg::SW_SHIFT'(0)}) + ORG_W'(region_left);
  assign origin_ptr = org_sum[18:3];

  assign reg_sum  = pixel_pointer + 16'(region_stride);
  assign reg_step = (END_W'(reg_sum) >= region_end) ? (reg_sum - 16'(region_fold)) : reg_sum;
  assign lin_sum  = pixel_pointer + 16'd1;
  assign lin_step = ({16'h0, lin_sum} >= PIX_LIM) ? 16'h0 : lin_sum;
  assign pix_step = region_enable ? reg_step : lin_step;
  assign pix_step_acc = ({16'h0, pix_step} >= PIX_LIM) ? 16'h0 : pix_step;

  assign col_sum  = color_pointer + 16'd1;
  assign col_step = (col_sum >= 16'(fbc_pkg::COL_DEPTH)) ? 16'h0 : col_sum;

  always_comb begin
    pixel_pointer_next = pixel_pointer;
    color_pointer_next = color_pointer;
    region_enable_next = region_enable;
    region_left_next   = region_left;
    region_top_next    = region_top;
    region_span_next   = region_span;
    current_mode_next  = current_mode;
    saved_mode_next    = saved_mode;
    result             = 8'h00;

    req           = '0;
    req.pix_rd    = start;
    req.col_rd    = start;
    req.pix_addr  = pixel_pointer[fbc_pkg::PIX_AW-1:0];
    req.col_addr  = color_pointer[fbc_pkg::COL_AW-1:0];
    req.pix_wdata = value_q;
    req.col_wdata = value_q;

    if (exec) begin
      case (cmd_q)
        CMD_COMMAND: begin
          unique case (value_q)
            OP_PPTR:     current_mode_next = M_PPTR_HI;
            OP_CPTR:     current_mode_next = M_CPTR_HI;
            OP_PIX:      current_mode_next = M_PIX_RW;
            OP_COL:      current_mode_next = M_COL_RW;
            OP_PDEC:     pixel_pointer_next = pixel_pointer - 16'd1;
            OP_CDEC:     color_pointer_next = color_pointer - 16'd1;
            OP_KEY: begin
              saved_mode_next   = current_mode;
              current_mode_next = M_KEY;
            end
            OP_ORIGIN:   current_mode_next = M_RX_HI;
            OP_SIZE:     current_mode_next = M_RW_HI;
            OP_NOREGION: begin
              region_enable_next = 1'b0;
              current_mode_next  = M_PPTR_HI;
            end
            OP_OR:       current_mode_next = M_OR;
            OP_XOR:      current_mode_next = M_XOR;
            OP_AND:      current_mode_next = M_AND;
            OP_ACK: begin
              saved_mode_next   = current_mode;
              current_mode_next = M_ACK;
            end
            default: ;
          endcase
        end
        CMD_WRITE: begin
          unique case (current_mode)
            M_PIX_RW: begin
              req.pix_we         = 1'b1;
              pixel_pointer_next = pix_step_acc;
            end
            M_COL_RW: begin
              req.col_we         = 1'b1;
              color_pointer_next = col_step;
            end
            M_PPTR_HI: begin
              pixel_pointer_next = {value_q, 8'h00};
              current_mode_next  = M_PPTR_LO;
              region_enable_next = 1'b0;
            end
            M_PPTR_LO: begin
              pixel_pointer_next = pixel_pointer | {8'h00, value_q};
              current_mode_next  = M_PIX_RW;
              region_enable_next = 1'b0;
            end
            M_CPTR_HI: begin
              color_pointer_next = {value_q, 8'h00};
              current_mode_next  = M_CPTR_LO;
            end
            M_CPTR_LO: begin
              color_pointer_next = color_pointer | {8'h00, value_q};
              current_mode_next  = M_PIX_RW;
            end
            M_RX_HI: begin
              region_left_next  = {value_q, 8'h00};
              current_mode_next = M_RX_LO;
            end
            M_RX_LO: begin
              region_left_next  = region_left | {8'h00, value_q};
              current_mode_next = M_RY_HI;
            end
            M_RY_HI: begin
              region_top_next   = {value_q, 8'h00};
              current_mode_next = M_RY_LO;
            end
            M_RY_LO: begin
              region_top_next    = org_top;
              current_mode_next  = M_PIX_RW;
              region_enable_next = 1'b1;
              pixel_pointer_next = origin_ptr;
            end
            M_RW_HI: begin
              region_span_next  = {value_q, 8'h00};
              current_mode_next = M_RW_LO;
            end
            M_RW_LO: begin
              region_span_next  = region_span | {8'h00, value_q};
              current_mode_next = M_RH_HI;
            end
            M_RH_HI:  current_mode_next = M_RH_LO;
            M_RH_LO: begin
              current_mode_next  = M_PIX_RW;
              region_enable_next = 1'b1;
              pixel_pointer_next = origin_ptr;
            end
            M_OR: begin
              req.pix_we         = 1'b1;
              req.pix_wdata      = pix_rdata | value_q;
              pixel_pointer_next = pix_step;
            end
            M_XOR: begin
              req.pix_we         = 1'b1;
              req.pix_wdata      = pix_rdata ^ value_q;
              pixel_pointer_next = pix_step;
            end
            M_AND: begin
              req.pix_we         = 1'b1;
              req.pix_wdata      = pix_rdata & value_q;
              pixel_pointer_next = pix_step;
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          unique case (current_mode)
            M_PIX_RW: begin
              result             = pix_rdata;
              pixel_pointer_next = pix_step_acc;
            end
            M_COL_RW: begin
              result             = col_rdata;
              color_pointer_next = col_step;
            end
            M_KEY: begin
              result            = key_q;
              current_mode_next = saved_mode;
            end
            M_ACK: begin
              result            = ACK_BYTE;
              current_mode_next = saved_mode;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q   <= cmd;
      value_q <= value;
      key_q   <= key_code;
    end
    region_stride <= stride_sum[16:3];
    region_fold   <= region_span[15:3];
    region_end    <= end_sum[END_SUM_W-1:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_pointer <= '0;
      color_pointer <= '0;
      region_enable <= 1'b0;
      region_left   <= '0;
      region_top    <= '0;
      region_span   <= '0;
      current_mode  <= M_PIX_RW;
      saved_mode    <= M_PIX_RW;
    end else begin
      pixel_pointer <= pixel_pointer_next;
      color_pointer <= color_pointer_next;
      region_enable <= region_enable_next;
      region_left   <= region_left_next;
      region_top    <= region_top_next;
      region_span   <= region_span_next;
      current_mode  <= current_mode_next;
      saved_mode    <= saved_mode_next;
    end
  end

endmodule

/* src/framebuffer_command_port_controller.sv */
// Top level: beat handshake, issue/execute sequencing and the result register.
// An accepted beat is registered, run in ST_EXEC, and its result loaded into read_data.
// No new beat is taken while one executes: the store read, then its write-back.
// A result held by out_stall keeps the input stalled until that result is taken.
// Reset: synchronous; afterwards a sweep clears the pixel and color stores,
// and the input stays stalled until it ends.
`timescale 1ns / 1ps

module framebuffer_command_port_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] value,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  logic              busy;
  logic              accept;
  logic [7:0]        pix_rdata;
  logic [7:0]        col_rdata;
  logic [7:0]        result;
  fbc_pkg::mem_req_t req;

  assign in_stall = (state != ST_IDLE) || busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  fbc_stores u_stores (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pix_rdata (pix_rdata),
    .col_rdata (col_rdata),
    .busy      (busy)
  );

  fbc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .exec      (state == ST_EXEC),
    .cmd       (cmd),
    .value     (value),
    .key_code  (key_code),
    .pix_rdata (pix_rdata),
    .col_rdata (col_rdata),
    .req       (req),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_EXEC) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (state == ST_EXEC) begin
      read_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("input beat possible during store clear");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted beat not executed");

  a_exec_to_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> out_valid)
    else $error("executed beat produced no result");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !accept)
    else $error("beat accepted while another executes");
`endif

endmodule

/* tb/framebuffer_command_port_controller_tb.sv */
// Self-checking testbench for the framebuffer command port controller.
`timescale 1ns / 1ps

module framebuffer_command_port_controller_tb;

  localparam logic [1:0] BUS_CMD   = 2'd0;
  localparam logic [1:0] BUS_WRITE = 2'd1;
  localparam logic [1:0] BUS_READ  = 2'd2;
  localparam logic [1:0] BUS_NOP   = 2'd3;

  localparam logic [7:0] OP_PIX_PTR       = 8'h00;
  localparam logic [7:0] OP_COL_PTR       = 8'h01;
  localparam logic [7:0] OP_PIX_ACCESS    = 8'h02;
  localparam logic [7:0] OP_COL_ACCESS    = 8'h03;
  localparam logic [7:0] OP_PIX_DEC       = 8'h04;
  localparam logic [7:0] OP_COL_DEC       = 8'h05;
  localparam logic [7:0] OP_KEYBOARD      = 8'h10;
  localparam logic [7:0] OP_REGION_ORIGIN = 8'h20;
  localparam logic [7:0] OP_REGION_SIZE   = 8'h21;
  localparam logic [7:0] OP_REGION_CLEAR  = 8'h22;
  localparam logic [7:0] OP_OR            = 8'h23;
  localparam logic [7:0] OP_XOR           = 8'h24;
  localparam logic [7:0] OP_AND           = 8'h25;
  localparam logic [7:0] OP_ACK           = 8'hFF;
  localparam logic [7:0] OP_UNUSED        = 8'h7E;
  localparam logic [7:0] ACK_BYTE         = 8'h42;

  localparam int RANDOM_TARGET = 880;
  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [4:0] {
    MODE_PIX_RW, MODE_COL_RW, MODE_PPTR_HI, MODE_PPTR_LO, MODE_CPTR_HI, MODE_CPTR_LO,
    MODE_KEY, MODE_LEFT_HI, MODE_LEFT_LO, MODE_TOP_HI, MODE_TOP_LO, MODE_SPAN_HI,
    MODE_SPAN_LO, MODE_HEIGHT_HI, MODE_HEIGHT_LO, MODE_OR, MODE_XOR, MODE_AND, MODE_ACK
  } port_mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
    logic [7:0] key;
  } bus_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [1:0] cmd = 2'd0;
  logic [7:0] value = 8'h00;
  logic [7:0] key_code = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] read_data;

  bus_beat_t  pending_beats[$];
  logic [7:0] expected_reads[$];
  int         mismatches = 0;
  int         beats_in = 0;

  // predicted port state
  logic [7:0] pixel_mem[fbc_pkg::PIX_DEPTH];
  logic [7:0] color_mem[fbc_pkg::COL_DEPTH];
  logic [15:0] pix_ptr, col_ptr, reg_left, reg_top, reg_span;
  logic        region_on;
  port_mode_t  port_mode, saved_mode;

  framebuffer_command_port_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .value(value), .key_code(key_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void step_pixel_ptr(bit access);
    int unsigned stop;
    if (region_on) begin
      pix_ptr = pix_ptr + 16'((32'(reg_span) + fbc_pkg::SCREEN_WIDTH) / 8);
      stop = (32'(reg_top) * fbc_pkg::SCREEN_WIDTH + 32'(reg_left) + 32'(reg_span)) / 8;
      if (32'(pix_ptr) >= stop) pix_ptr = pix_ptr - reg_span / 16'd8;
    end else begin
      pix_ptr = pix_ptr + 16'd1;
      if (32'(pix_ptr) >= fbc_pkg::PIX_DEPTH) pix_ptr = 16'd0;
    end
    if (access && 32'(pix_ptr) >= fbc_pkg::PIX_DEPTH) pix_ptr = 16'd0;
  endfunction

  function automatic void step_color_ptr();
    col_ptr = col_ptr + 16'd1;
    if (32'(col_ptr) >= fbc_pkg::COL_DEPTH) col_ptr = 16'd0;
  endfunction

  function automatic void load_region_origin();
    port_mode = MODE_PIX_RW;
    region_on = 1'b1;
    pix_ptr = 16'((32'(reg_top) * fbc_pkg::SCREEN_WIDTH + 32'(reg_left)) / 8);
  endfunction

  function automatic logic [7:0] compute_read_data(logic [1:0] op, logic [7:0] v,
                                                   logic [7:0] k);
    logic [7:0] r;
    r = 8'h00;
    case (op)
      BUS_CMD: begin
        case (v)
          OP_PIX_PTR: port_mode = MODE_PPTR_HI;
          OP_COL_PTR: port_mode = MODE_CPTR_HI;
          OP_PIX_ACCESS: port_mode = MODE_PIX_RW;
          OP_COL_ACCESS: port_mode = MODE_COL_RW;
          OP_PIX_DEC: pix_ptr = pix_ptr - 16'd1;
          OP_COL_DEC: col_ptr = col_ptr - 16'd1;
          OP_KEYBOARD: begin
            saved_mode = port_mode;
            port_mode = MODE_KEY;
          end
          OP_REGION_ORIGIN: port_mode = MODE_LEFT_HI;
          OP_REGION_SIZE: port_mode = MODE_SPAN_HI;
          OP_REGION_CLEAR: begin
            region_on = 1'b0;
            port_mode = MODE_PPTR_HI;
          end
          OP_OR: port_mode = MODE_OR;
          OP_XOR: port_mode = MODE_XOR;
          OP_AND: port_mode = MODE_AND;
          OP_ACK: begin
            saved_mode = port_mode;
            port_mode = MODE_ACK;
          end
          default: ;
        endcase
      end
      BUS_WRITE: begin
        case (port_mode)
          MODE_PIX_RW: begin
            pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] = v;
            step_pixel_ptr(1'b1);
          end
          MODE_COL_RW: begin
            color_mem[col_ptr % fbc_pkg::COL_DEPTH] = v;
            step_color_ptr();
          end
          MODE_PPTR_HI: begin
            pix_ptr = {v, 8'h00};
            port_mode = MODE_PPTR_LO;
            region_on = 1'b0;
          end
          MODE_PPTR_LO: begin
            pix_ptr = pix_ptr | {8'h00, v};
            port_mode = MODE_PIX_RW;
            region_on = 1'b0;
          end
          MODE_CPTR_HI: begin
            col_ptr = {v, 8'h00};
            port_mode = MODE_CPTR_LO;
          end
          MODE_CPTR_LO: begin
            col_ptr = col_ptr | {8'h00, v};
            port_mode = MODE_PIX_RW;
          end
          MODE_LEFT_HI: begin
            reg_left = {v, 8'h00};
            port_mode = MODE_LEFT_LO;
          end
          MODE_LEFT_LO: begin
            reg_left = reg_left | {8'h00, v};
            port_mode = MODE_TOP_HI;
          end
          MODE_TOP_HI: begin
            reg_top = {v, 8'h00};
            port_mode = MODE_TOP_LO;
          end
          MODE_TOP_LO: begin
            reg_top = reg_top | {8'h00, v};
            load_region_origin();
          end
          MODE_SPAN_HI: begin
            reg_span = {v, 8'h00};
            port_mode = MODE_SPAN_LO;
          end
          MODE_SPAN_LO: begin
            reg_span = reg_span | {8'h00, v};
            port_mode = MODE_HEIGHT_HI;
          end
          MODE_HEIGHT_HI: port_mode = MODE_HEIGHT_LO;
          MODE_HEIGHT_LO: load_region_origin();
          MODE_OR: begin
            pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] =
              pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] | v;
            step_pixel_ptr(1'b0);
          end
          MODE_XOR: begin
            pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] =
              pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] ^ v;
            step_pixel_ptr(1'b0);
          end
          MODE_AND: begin
            pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] =
              pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH] & v;
            step_pixel_ptr(1'b0);
          end
          default: ;
        endcase
      end
      BUS_READ: begin
        case (port_mode)
          MODE_PIX_RW: begin
            r = pixel_mem[pix_ptr % fbc_pkg::PIX_DEPTH];
            step_pixel_ptr(1'b1);
          end
          MODE_COL_RW: begin
            r = color_mem[col_ptr % fbc_pkg::COL_DEPTH];
            step_color_ptr();
          end
          MODE_KEY: begin
            r = k;
            port_mode = saved_mode;
          end
          MODE_ACK: begin
            r = ACK_BYTE;
            port_mode = saved_mode;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_beat(logic [1:0] c, logic [7:0] v);
    pending_beats.push_back('{cmd: c, value: v, key: 8'($urandom)});
  endtask

  task automatic push_word(logic [15:0] w);
    push_beat(BUS_WRITE, w[15:8]);
    push_beat(BUS_WRITE, w[7:0]);
  endtask

  // mixed data writes and reads in whatever mode is current
  task automatic push_traffic(int n);
    for (int i = 0; i < n; i++)
      push_beat(($urandom_range(0, 1) == 0) ? BUS_WRITE : BUS_READ, 8'($urandom));
  endtask

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("MISMATCH %s: expected %02h got %02h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // sender: bursts of beats separated by random gaps
  int gap_left = 0;
  int burst_left = 0;
  bus_beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reads.push_back(compute_read_data(cmd, value, key_code));
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat = pending_beats.pop_front();
          cmd <= next_beat.cmd;
          value <= next_beat.value;
          key_code <= next_beat.key;
          in_valid <= 1'b1;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern in phases, plus one long hold-off
  int  stall_style = 0;
  int  phase_left = 0;
  int  hold_left = 0;
  bit  held_off = 1'b0;
  logic [3:0] stall_tick = 4'd0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_off && beats_in >= 300) begin
      held_off = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_style = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 120);
      end else begin
        phase_left--;
      end
      stall_tick = stall_tick + 4'd1;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[1];
      endcase
    end
  end

  logic [7:0] want_read;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("unexpected beat, read_data", 8'h00, read_data);
      end else begin
        want_read = expected_reads.pop_front();
        if (read_data !== want_read) report_mismatch("read_data", want_read, read_data);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  logic [15:0] ptr;
  logic [7:0]  op;
  int          n;

  initial begin
    for (int i = 0; i < fbc_pkg::PIX_DEPTH; i++) pixel_mem[i] = 8'h00;
    for (int i = 0; i < fbc_pkg::COL_DEPTH; i++) color_mem[i] = 8'h00;
    pix_ptr = 16'd0;
    col_ptr = 16'd0;
    reg_left = 16'd0;
    reg_top = 16'd0;
    reg_span = 16'd0;
    region_on = 1'b0;
    port_mode = MODE_PIX_RW;
    saved_mode = MODE_PIX_RW;

    // directed: reserved bus code, acknowledge, keyboard, pointer past the store,
    // logic ops, unknown command, color wrap, widest region
    push_beat(BUS_NOP, 8'hFF);
    push_beat(BUS_CMD, OP_ACK);
    push_beat(BUS_READ, 8'h00);
    push_beat(BUS_CMD, OP_KEYBOARD);
    push_beat(BUS_WRITE, 8'hAA);
    pending_beats.push_back('{cmd: BUS_READ, value: 8'h00, key: 8'hFF});
    push_beat(BUS_CMD, OP_PIX_PTR);
    push_word(16'hFFFF);
    push_beat(BUS_WRITE, 8'h5A);
    push_beat(BUS_CMD, OP_PIX_DEC);
    push_beat(BUS_READ, 8'h00);
    push_beat(BUS_CMD, OP_OR);
    push_beat(BUS_WRITE, 8'hF0);
    push_beat(BUS_READ, 8'hFF);
    push_beat(BUS_CMD, OP_XOR);
    push_beat(BUS_WRITE, 8'hFF);
    push_beat(BUS_CMD, OP_AND);
    push_beat(BUS_WRITE, 8'h00);
    push_beat(BUS_CMD, OP_UNUSED);
    push_beat(BUS_CMD, OP_COL_DEC);
    push_beat(BUS_CMD, OP_COL_ACCESS);
    push_beat(BUS_WRITE, 8'h81);
    push_beat(BUS_CMD, OP_REGION_SIZE);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_beat(BUS_READ, 8'h00);

    while (pending_beats.size() < RANDOM_TARGET) begin
      case ($urandom_range(0, 10))
        0, 1: begin
          push_beat(BUS_CMD, ($urandom_range(0, 1) == 0) ? OP_PIX_PTR : OP_REGION_CLEAR);
          ptr = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 255));
          push_word(ptr);
          push_traffic($urandom_range(1, 8));
        end
        2: begin
          push_beat(BUS_CMD, OP_COL_PTR);
          ptr = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, fbc_pkg::COL_DEPTH - 1));
          push_word(ptr);
          push_beat(BUS_CMD, OP_COL_ACCESS);
          push_traffic($urandom_range(1, 8));
        end
        3, 4: begin
          if ($urandom_range(0, 1) == 0) begin
            push_beat(BUS_CMD, OP_REGION_SIZE);
            ptr = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(1, 16) * 8);
            push_word(ptr);
            push_word(16'($urandom));
          end
          push_beat(BUS_CMD, OP_REGION_ORIGIN);
          push_word(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)));
          push_word(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)));
          push_traffic($urandom_range(2, 10));
        end
        5, 6: begin
          // logic op run, then rewind and read the bytes back
          ptr = 16'($urandom_range(0, fbc_pkg::PIX_DEPTH - 1));
          n = $urandom_range(1, 6);
          case ($urandom_range(0, 2))
            0: op = OP_OR;
            1: op = OP_XOR;
            default: op = OP_AND;
          endcase
          push_beat(BUS_CMD, OP_PIX_PTR);
          push_word(ptr);
          push_beat(BUS_CMD, op);
          for (int i = 0; i < n; i++) push_beat(BUS_WRITE, 8'($urandom));
          if ($urandom_range(0, 2) == 0) push_beat(BUS_READ, 8'($urandom));
          push_beat(BUS_CMD, OP_PIX_PTR);
          push_word(ptr);
          for (int i = 0; i < n; i++) push_beat(BUS_READ, 8'($urandom));
        end
        7: begin
          push_beat(BUS_CMD, ($urandom_range(0, 1) == 0) ? OP_KEYBOARD : OP_ACK);
          if ($urandom_range(0, 2) == 0) push_beat(BUS_WRITE, 8'($urandom));
          push_beat(BUS_READ, 8'($urandom));
          push_traffic($urandom_range(0, 3));
        end
        8: begin
          op = ($urandom_range(0, 1) == 0) ? OP_PIX_DEC : OP_COL_DEC;
          for (int i = 0; i < $urandom_range(1, 3); i++) push_beat(BUS_CMD, op);
          push_beat(BUS_CMD, ($urandom_range(0, 1) == 0) ? OP_PIX_ACCESS : OP_COL_ACCESS);
          push_traffic($urandom_range(1, 4));
        end
        9: begin
          push_beat(BUS_CMD, ($urandom_range(0, 1) == 0) ? OP_PIX_ACCESS : OP_COL_ACCESS);
          push_traffic($urandom_range(1, 6));
        end
        default: begin
          for (int i = 0; i < $urandom_range(1, 4); i++)
            push_beat(2'($urandom_range(0, 3)), 8'($urandom));
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || expected_reads.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/fbc_pkg.sv
src/fbc_stores.sv
src/fbc_engine.sv
src/framebuffer_command_port_controller.sv
tb/framebuffer_command_port_controller_tb.sv
